/* design/assert_macros.svh */
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define RABP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define RABP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rabp_pkg.sv */
// Package with the types, codes and constants of the request parser.
`timescale 1ns / 1ps

package rabp_pkg;

    // Default widths of the length and count numbers.
    localparam int LENGTH_BITS_DEF = 20;
    localparam int COUNT_BITS_DEF  = 16;

    // Widths of the result fields.
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 20;
    localparam int INDEX_W = 16;
    localparam int ERR_W   = 3;
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 3;

    // Protocol characters.
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ARRAY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_STAR      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_COUNT_LF  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_DOLLAR    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_LENGTH_LF = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_DIGIT    = 3'd4;

    // Parse phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_DROP     = 9'b000000010,
        PH_COUNT    = 9'b000000100,
        PH_COUNT_LF = 9'b000001000,
        PH_DOLLAR   = 9'b000010000,
        PH_LEN      = 9'b000100000,
        PH_LEN_LF   = 9'b001000000,
        PH_PAYLOAD  = 9'b010000000,
        PH_TRAILER  = 9'b100000000
    } rabp_phase_t;

    // One result item as it travels from the parser to the output stage.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] element_index;
        logic               last_of_element;
        logic               last_of_message;
        logic [ERR_W-1:0]   error_code;
    } rabp_result_t;

endpackage

/* design/resp_array_bulk_parser_top.sv */
// Top level of the byte-serial request parser for arrays of bulk strings.
//
// Usage: request bytes enter on the s_ channel, one byte per item (s_tdata).
// Each accepted byte gives zero or one result item on the m_ channel: the
// array header with its count, each element header with its length, each
// payload byte, or one error item after a protocol fault, after which bytes
// are dropped until the next star. m_tlast marks the item that ends the
// request. The cfg_ channel writes uppercase_first (reset 1), which folds
// letters of element 0 to upper case; write it only while the block is idle.
// Results are registered in the output or skid slot. Throughput: one byte
// per cycle while s_tready is high, set by the single state update and
// times-ten accumulate between the state registers and the output slot.
// Reset (aresetn low, synchronous) returns the parser to waiting for a star
// and empties the output. When the receiver stalls, a two-entry output
// buffer holds results; s_tready falls only once both entries are full.
`timescale 1ns / 1ps

module resp_array_bulk_parser_top #(
    parameter int LENGTH_BITS = rabp_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = rabp_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input bytes. s_tdata[7:0] data_byte.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: [19:0] value, [35:20] element_index, [38:36] error_code, [39] zero.
    output logic [rabp_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: [1:0] kind, [2] last_of_element.
    output logic [rabp_pkg::TUSER_W-1:0] m_tuser,
    output logic                         m_tlast,
    // Configuration: cfg_data[0] uppercase_first.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data
);
    import rabp_pkg::*;

    logic         uppercase_first_reg;
    logic         in_accept;
    logic         result_valid;
    rabp_result_t result;
    rabp_result_t m_result;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uppercase_first_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            uppercase_first_reg <= cfg_data;
        end
    end

    rabp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .data_byte       (s_tdata),
        .uppercase_first (uppercase_first_reg),
        .result_valid    (result_valid),
        .result          (result)
    );

    rabp_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (in_accept && result_valid),
        .push_data  (result),
        .in_ready   (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_result)
    );

    // Pack the result item onto the stream ports.
    assign m_tdata = {1'b0, m_result.error_code, m_result.element_index, m_result.value};
    assign m_tuser = {m_result.last_of_element, m_result.kind};
    assign m_tlast = m_result.last_of_message;

endmodule

/* design/rabp_parse_core.sv */
// Parse state machine: one byte in, at most one result out, each accepting cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rabp_parse_core #(
    parameter int LENGTH_BITS = rabp_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = rabp_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          data_byte,
    input  logic                uppercase_first,
    output logic                result_valid,
    output rabp_pkg::rabp_result_t result
);
    import rabp_pkg::*;

    localparam int ACC_W = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
    localparam int NUM_W = ACC_W + 4;
    localparam logic [NUM_W-1:0] COUNT_MAX = NUM_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [NUM_W-1:0] LEN_MAX   = NUM_W'((64'd1 << LENGTH_BITS) - 64'd1);

    rabp_phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [COUNT_BITS-1:0]  elems_left_reg, elems_left_next;
    logic [COUNT_BITS-1:0]  cur_elem_reg, cur_elem_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]             skip_left_reg, skip_left_next;

    logic                   is_digit;
    logic [NUM_W-1:0]       acc_ext;
    logic [NUM_W-1:0]       digit_sum;
    logic                   count_ok;
    logic                   len_ok;
    logic [31:0]            idx_wide;
    logic [31:0]            acc_wide;
    logic [LENGTH_BITS-1:0] bytes_dec;
    logic [1:0]             skip_dec;
    logic [COUNT_BITS-1:0]  elems_dec;
    logic [7:0]             payload_byte;
    logic                   last_el;
    logic                   start_req;
    logic                   do_fail;
    logic [ERR_W-1:0]       fail_code;

    // Decimal accumulate: acc * 10 + digit, checked against the range limits.
    always_comb begin
        is_digit  = (data_byte >= CHAR_0) && (data_byte <= CHAR_9);
        acc_ext   = NUM_W'(acc_reg);
        digit_sum = (acc_ext << 3) + (acc_ext << 1) + NUM_W'(data_byte - CHAR_0);
        count_ok  = is_digit && (digit_sum <= COUNT_MAX);
        len_ok    = is_digit && (digit_sum <= LEN_MAX);
        idx_wide  = 32'(cur_elem_reg);
        acc_wide  = 32'(acc_reg);
        bytes_dec = (bytes_left_reg == '0) ? '0 : bytes_left_reg - LENGTH_BITS'(1);
        skip_dec  = (skip_left_reg == 2'd0) ? 2'd0 : skip_left_reg - 2'd1;
        elems_dec = (elems_left_reg == '0) ? '0 : elems_left_reg - COUNT_BITS'(1);
        last_el   = (bytes_left_reg == LENGTH_BITS'(1));
        // Letters of the command name may be folded to upper case.
        if ((cur_elem_reg == '0) && uppercase_first &&
            (data_byte >= CHAR_LOW_A) && (data_byte <= CHAR_LOW_Z)) begin
            payload_byte = data_byte - CASE_OFFSET;
        end else begin
            payload_byte = data_byte;
        end
    end

    // Next state and result for the byte on the input.
    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        elems_left_next = elems_left_reg;
        cur_elem_next   = cur_elem_reg;
        bytes_left_next = bytes_left_reg;
        skip_left_next  = skip_left_reg;
        start_req       = 1'b0;
        do_fail         = 1'b0;
        fail_code       = ERR_NONE;
        result_valid    = 1'b0;
        result          = '0;

        case (phase_reg)
            PH_DROP: begin
                start_req = (data_byte == CHAR_STAR);
            end
            PH_COUNT: begin
                if (data_byte == CHAR_CR) begin
                    phase_next = PH_COUNT_LF;
                end else if (count_ok) begin
                    acc_next = digit_sum[ACC_W-1:0];
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_DIGIT;
                end
            end
            PH_COUNT_LF: begin
                if (data_byte != CHAR_LF) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_COUNT_LF;
                end else begin
                    elems_left_next        = acc_reg[COUNT_BITS-1:0];
                    cur_elem_next          = '0;
                    phase_next             = (acc_reg == '0) ? PH_IDLE : PH_DOLLAR;
                    result_valid           = 1'b1;
                    result.kind            = KIND_ARRAY;
                    result.value           = acc_wide[VALUE_W-1:0];
                    result.last_of_message = (acc_reg == '0);
                end
            end
            PH_DOLLAR: begin
                if (data_byte != CHAR_DOLLAR) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_DOLLAR;
                end else begin
                    acc_next   = '0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (data_byte == CHAR_CR) begin
                    phase_next = PH_LEN_LF;
                end else if (len_ok) begin
                    acc_next = digit_sum[ACC_W-1:0];
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_DIGIT;
                end
            end
            PH_LEN_LF: begin
                if (data_byte != CHAR_LF) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_LENGTH_LF;
                end else begin
                    bytes_left_next = acc_reg[LENGTH_BITS-1:0];
                    if (acc_reg == '0) begin
                        phase_next     = PH_TRAILER;
                        skip_left_next = 2'd2;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                    result_valid           = 1'b1;
                    result.kind            = KIND_ELEMENT;
                    result.value           = acc_wide[VALUE_W-1:0];
                    result.element_index   = idx_wide[INDEX_W-1:0];
                    result.last_of_element = (acc_reg == '0);
                    result.last_of_message = (acc_reg == '0) &&
                                             (elems_left_reg == COUNT_BITS'(1));
                end
            end
            PH_PAYLOAD: begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == '0) begin
                    phase_next     = PH_TRAILER;
                    skip_left_next = 2'd2;
                end
                result_valid           = 1'b1;
                result.kind            = KIND_PAYLOAD;
                result.value           = VALUE_W'(payload_byte);
                result.element_index   = idx_wide[INDEX_W-1:0];
                result.last_of_element = last_el;
                result.last_of_message = last_el && (elems_left_reg == COUNT_BITS'(1));
            end
            PH_TRAILER: begin
                // Two bytes after each payload are skipped unchecked.
                skip_left_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    elems_left_next = elems_dec;
                    cur_elem_next   = cur_elem_reg + COUNT_BITS'(1);
                    phase_next      = (elems_dec == '0) ? PH_IDLE : PH_DOLLAR;
                end
            end
            default: begin
                // Waiting for the star that opens a request.
                if (data_byte == CHAR_STAR) begin
                    start_req = 1'b1;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_STAR;
                end
            end
        endcase

        // A star opens a fresh request.
        if (start_req) begin
            phase_next      = PH_COUNT;
            acc_next        = '0;
            cur_elem_next   = '0;
            elems_left_next = '0;
            bytes_left_next = '0;
            skip_left_next  = 2'd0;
        end

        // A protocol fault gives one error item and then drops bytes.
        if (do_fail) begin
            phase_next           = PH_DROP;
            result_valid         = 1'b1;
            result               = '0;
            result.kind          = KIND_ERROR;
            result.element_index = idx_wide[INDEX_W-1:0];
            result.error_code    = fail_code;
        end
    end

    // State registers advance on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            acc_reg        <= '0;
            elems_left_reg <= '0;
            cur_elem_reg   <= '0;
            bytes_left_reg <= '0;
            skip_left_reg  <= 2'd0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            elems_left_reg <= elems_left_next;
            cur_elem_reg   <= cur_elem_next;
            bytes_left_reg <= bytes_left_next;
            skip_left_reg  <= skip_left_next;
        end
    end

    // An accepted error item always leaves the parser dropping bytes.
    `RABP_ASSERT(a_error_drops, aclk, aresetn, ((in_accept && result_valid && (result.kind == KIND_ERROR)) |=> (phase_reg == PH_DROP)), "error item did not lead to the drop phase")
    // Payload is only parsed while bytes remain in the element.
    `RABP_ASSERT(a_payload_left, aclk, aresetn, ((phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != '0)), "payload phase with no bytes left")
    // The trailer phase always has bytes left to skip.
    `RABP_ASSERT(a_trailer_left, aclk, aresetn, ((phase_reg == PH_TRAILER) |-> (skip_left_reg != 2'd0)), "trailer phase with nothing to skip")

endmodule

/* design/rabp_out_reg.sv */
// Two-entry output register that lets the parser keep taking bytes under stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rabp_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    input  rabp_pkg::rabp_result_t push_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rabp_pkg::rabp_result_t m_data
);
    import rabp_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    rabp_result_t out_data_reg;
    rabp_result_t skid_data_reg;
    logic         pop;

    assign pop      = out_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Control: the output slot holds the older item, the skid slot the newer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= push_valid;
            end else begin
                out_valid_reg <= push_valid;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= push_valid;
        end else if (push_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Item payload moves without reset.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end else if (!out_valid_reg) begin
            out_data_reg <= push_data;
        end else if (push_valid) begin
            skid_data_reg <= push_data;
        end
    end

    // The skid slot is never filled while the output slot is empty.
    `RABP_ASSERT(a_skid_order, aclk, aresetn, (skid_valid_reg |-> out_valid_reg), "skid slot holds an item ahead of the output slot")
    // The skid slot only fills when an item is pushed into a stalled output.
    `RABP_ASSERT(a_skid_fill, aclk, aresetn, ($rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && push_valid)), "skid slot filled without a stall")
    // No item is pushed while the buffer is full.
    `RABP_ASSERT(a_no_overflow, aclk, aresetn, ((skid_valid_reg && !pop) |-> !push_valid), "item pushed into a full output buffer")

endmodule

/* bench/rabp_parse_checker.sv */
// Checker that predicts and compares the result items of the request parser.
`timescale 1ns / 1ps

module rabp_parse_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    // s_tdata: [7:0] data_byte.
    input  logic [7:0]                   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: [19:0] value, [35:20] element_index, [38:36] error_code, [39] zero.
    input  logic [rabp_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: [1:0] kind, [2] last_of_element.
    input  logic [rabp_pkg::TUSER_W-1:0] m_tuser,
    input  logic                         m_tlast,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic                         cfg_data,
    output int                           fail_count,
    output int                           pending,
    output int                           result_count,
    output int                           error_count
);
    import rabp_pkg::*;

    localparam longint unsigned COUNT_LIMIT  = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam longint unsigned LENGTH_LIMIT = (64'd1 << LENGTH_BITS_DEF) - 1;

    // Shadow copy of the parser state and its one register.
    rabp_phase_t                phase;
    longint unsigned            number_acc;
    logic [COUNT_BITS_DEF-1:0]  elements_left;
    logic [COUNT_BITS_DEF-1:0]  current_element;
    logic [LENGTH_BITS_DEF-1:0] bytes_left;
    logic [1:0]                 skip_left;
    logic                       upcase_first;

    rabp_result_t expected_results[$];
    rabp_result_t oldest;
    int           bad_fields;

    // Queue one expected result item.
    task automatic emit(input logic [KIND_W-1:0] kind, input longint unsigned value,
                        input logic [INDEX_W-1:0] index, input logic last_el,
                        input logic last_msg, input logic [ERR_W-1:0] code);
        rabp_result_t r;
        r.kind            = kind;
        r.value           = value[VALUE_W-1:0];
        r.element_index   = index;
        r.last_of_element = last_el;
        r.last_of_message = last_msg;
        r.error_code      = code;
        expected_results.push_back(r);
    endtask

    // A protocol fault gives one error item and then bytes are dropped.
    task automatic raise_error(input logic [ERR_W-1:0] code);
        phase = PH_DROP;
        emit(KIND_ERROR, 0, current_element, 1'b0, 1'b0, code);
    endtask

    task automatic start_request();
        phase           = PH_COUNT;
        number_acc      = 0;
        current_element = '0;
        elements_left   = '0;
        bytes_left      = '0;
        skip_left       = '0;
    endtask

    // Accumulates one decimal digit; ok stays low for a non-digit or overflow.
    task automatic take_digit(input logic [7:0] b, input longint unsigned limit,
                              output bit ok);
        longint unsigned next_v;
        ok = 1'b0;
        if (b >= CHAR_0 && b <= CHAR_9) begin
            next_v = number_acc * 10 + longint'(b - CHAR_0);
            if (next_v <= limit) begin
                number_acc = next_v;
                ok = 1'b1;
            end
        end
    endtask

    // Advances the shadow parser by one accepted byte.
    task automatic parse_byte(input logic [7:0] b);
        bit         ok;
        logic       empty;
        logic       last_el;
        logic [7:0] v;
        case (phase)
            PH_DROP: begin
                if (b == CHAR_STAR) start_request();
            end
            PH_COUNT: begin
                if (b == CHAR_CR) begin
                    phase = PH_COUNT_LF;
                end else begin
                    take_digit(b, COUNT_LIMIT, ok);
                    if (!ok) raise_error(ERR_BAD_DIGIT);
                end
            end
            PH_COUNT_LF: begin
                if (b != CHAR_LF) begin
                    raise_error(ERR_NO_COUNT_LF);
                end else begin
                    elements_left   = number_acc[COUNT_BITS_DEF-1:0];
                    current_element = '0;
                    phase = (number_acc == 0) ? PH_IDLE : PH_DOLLAR;
                    emit(KIND_ARRAY, number_acc, '0, 1'b0, number_acc == 0, ERR_NONE);
                end
            end
            PH_DOLLAR: begin
                if (b != CHAR_DOLLAR) begin
                    raise_error(ERR_NO_DOLLAR);
                end else begin
                    number_acc = 0;
                    phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b == CHAR_CR) begin
                    phase = PH_LEN_LF;
                end else begin
                    take_digit(b, LENGTH_LIMIT, ok);
                    if (!ok) raise_error(ERR_BAD_DIGIT);
                end
            end
            PH_LEN_LF: begin
                if (b != CHAR_LF) begin
                    raise_error(ERR_NO_LENGTH_LF);
                end else begin
                    empty      = (number_acc == 0);
                    bytes_left = number_acc[LENGTH_BITS_DEF-1:0];
                    if (empty) begin
                        phase     = PH_TRAILER;
                        skip_left = 2'd2;
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                    emit(KIND_ELEMENT, number_acc, current_element, empty,
                         empty && elements_left == 1, ERR_NONE);
                end
            end
            PH_PAYLOAD: begin
                v       = b;
                last_el = (bytes_left == 1);
                // Letters of the command name may be folded to upper case.
                if (current_element == 0 && upcase_first &&
                    b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
                    v = b - CASE_OFFSET;
                end
                if (bytes_left != 0) bytes_left = bytes_left - 1;
                if (bytes_left == 0) begin
                    phase     = PH_TRAILER;
                    skip_left = 2'd2;
                end
                emit(KIND_PAYLOAD, v, current_element, last_el,
                     last_el && elements_left == 1, ERR_NONE);
            end
            PH_TRAILER: begin
                // The two trailing bytes are skipped without any check.
                if (skip_left != 0) skip_left = skip_left - 1;
                if (skip_left == 0) begin
                    if (elements_left != 0) elements_left = elements_left - 1;
                    current_element = current_element + 1;
                    phase = (elements_left == 0) ? PH_IDLE : PH_DOLLAR;
                end
            end
            default: begin
                if (b == CHAR_STAR) start_request();
                else raise_error(ERR_NO_STAR);
            end
        endcase
    endtask

    function automatic int field_differs(input string name, input longint unsigned exp_v,
                                         input longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("t=%0t mismatch in %s: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase           = PH_IDLE;
            number_acc      = 0;
            elements_left   = '0;
            current_element = '0;
            bytes_left      = '0;
            skip_left       = '0;
            upcase_first    = 1'b1;
            expected_results.delete();
            fail_count      = 0;
            result_count    = 0;
            error_count     = 0;
        end else begin
            if (cfg_valid && cfg_ready) upcase_first = cfg_data;
            if (s_tvalid && s_tready) parse_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                result_count++;
                if (m_tuser[1:0] == KIND_ERROR) error_count++;
                if (expected_results.size() == 0) begin
                    $display("t=%0t unexpected result item: kind %0d value %0d index %0d",
                             $time, m_tuser[1:0], m_tdata[19:0], m_tdata[35:20]);
                    fail_count++;
                end else begin
                    oldest     = expected_results.pop_front();
                    bad_fields = 0;
                    bad_fields += field_differs("kind", oldest.kind, m_tuser[1:0]);
                    bad_fields += field_differs("value", oldest.value, m_tdata[19:0]);
                    bad_fields += field_differs("element_index", oldest.element_index,
                                                m_tdata[35:20]);
                    bad_fields += field_differs("last_of_element", oldest.last_of_element,
                                                m_tuser[2]);
                    bad_fields += field_differs("last_of_message", oldest.last_of_message,
                                                m_tlast);
                    bad_fields += field_differs("error_code", oldest.error_code,
                                                m_tdata[38:36]);
                    if (bad_fields != 0) fail_count++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

/* bench/tb_resp_array_bulk_parser_top.sv */
// Top of the parser testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_resp_array_bulk_parser_top;
    import rabp_pkg::*;

    localparam int CLK_PERIOD = 4;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int error_count;

    int         src_idle_pct;
    int         sink_idle_pct;
    int         bytes_sent;
    int         cfg_writes;
    logic [7:0] req_bytes[$];

    resp_array_bulk_parser_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rabp_parse_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .error_count  (error_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The receiver stalls at random, one decision per cycle.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Offers one byte, with random gaps before it, and waits for acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_queued();
        while (req_bytes.size() > 0) send_byte(req_bytes.pop_front());
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) req_bytes.push_back(txt[i]);
    endtask

    // Decimal number, sometimes empty for zero or with a leading zero.
    task automatic push_number(input int unsigned v);
        int unsigned digits[$];
        if (v == 0 && $urandom_range(3) == 0) return;
        if ($urandom_range(7) == 0) req_bytes.push_back(CHAR_0);
        do begin
            digits.push_front(v % 10);
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) req_bytes.push_back(CHAR_0 + 8'(digits[i]));
    endtask

    // One request with random content, well-formed but for trailers that may be random bytes.
    task automatic push_request();
        int unsigned n_elems;
        int unsigned len;
        n_elems = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        req_bytes.push_back(CHAR_STAR);
        push_number(n_elems);
        req_bytes.push_back(CHAR_CR);
        req_bytes.push_back(CHAR_LF);
        for (int i = 0; i < n_elems; i++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            req_bytes.push_back(CHAR_DOLLAR);
            push_number(len);
            req_bytes.push_back(CHAR_CR);
            req_bytes.push_back(CHAR_LF);
            // The command name leans toward letters and their neighbors.
            for (int j = 0; j < len; j++) begin
                if (i == 0 && $urandom_range(1) == 0)
                    req_bytes.push_back(8'($urandom_range(8'h60, 8'h7B)));
                else
                    req_bytes.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(9) < 7) begin
                req_bytes.push_back(CHAR_CR);
                req_bytes.push_back(CHAR_LF);
            end else begin
                req_bytes.push_back(8'($urandom_range(255)));
                req_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // Mostly clean requests, some with one byte corrupted, some plain noise.
    task automatic push_random_item();
        int pick;
        int first;
        int pos;
        pick = $urandom_range(99);
        if (pick < 75) begin
            push_request();
        end else if (pick < 90) begin
            first = req_bytes.size();
            push_request();
            pos = $urandom_range(first, req_bytes.size() - 1);
            req_bytes[pos] = 8'($urandom_range(255));
        end else begin
            repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Waits until every expected item has come, plus a short settle time.
    task automatic wait_quiet();
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_upcase(input logic v);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int src_pct, input int sink_pct, input int n_bytes);
        int start_count;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < n_bytes) begin
            push_random_item();
            send_queued();
        end
        s_tvalid <= 1'b0;
    endtask

    // Main sequence: reset, directed cases, then three random phases.
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        src_idle_pct  = 20;
        sink_idle_pct = 66;
        bytes_sent    = 0;
        cfg_writes    = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A non-star byte while idle faults; the next byte is dropped.
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'hFF);
        // Empty count reads as zero and ends the request at once.
        push_text("*\r\n");
        // Largest count and largest length, then a missing LF after the length.
        push_text("*65535\r\n$1048575\rx");
        // A count one past the limit faults on its last digit.
        push_text("*65536");
        send_queued();
        s_tvalid <= 1'b0;

        write_upcase(1'b0);
        run_random(20, 66, 580);
        write_upcase(1'b1);
        run_random(66, 20, 580);
        write_upcase(1'b0);
        run_random(0, 0, 590);

        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("run covered %0d request bytes and %0d result items, %0d of them faults,",
                 bytes_sent, result_count, error_count);
        $display("with %0d register writes and three idle patterns on both channels.",
                 cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* resp_array_bulk_parser_top.f */
+incdir+design
design/rabp_pkg.sv
design/rabp_parse_core.sv
design/rabp_out_reg.sv
design/resp_array_bulk_parser_top.sv
bench/rabp_parse_checker.sv
bench/tb_resp_array_bulk_parser_top.sv
